FILE: src/kcq_pkg.sv
// Shared widths, codes and control types for the keyed circular queue.
package kcq_pkg;

	localparam int ACT_W = 2;
	localparam int KEY_W = 32;
	localparam int PAY_W = 16;
	localparam int ST_W  = 3;
	localparam int OCC_W = 7;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_DUP      = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	// Control broadcast to every cell of the ring.
	typedef struct packed {
		logic shift;  // rotate: each cell takes its upper neighbor
		logic wr;     // load the new record into the addressed cell
	} cell_ctl_t;

endpackage

FILE: src/kcq_intf.sv
// Request and response channel interfaces of the keyed circular queue.
interface kcq_req_if;
	import kcq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic signed [KEY_W-1:0] key;
	logic [PAY_W-1:0]        payload;
	modport source(output valid, action, key, payload, input ready);
	modport sink(input valid, action, key, payload, output ready);
endinterface

interface kcq_rsp_if;
	import kcq_pkg::*;
	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic             found;
	logic [PAY_W-1:0] found_payload;
	logic [OCC_W-1:0] occupancy;
	modport source(output valid, status, found, found_payload, occupancy, input ready);
	modport sink(input valid, status, found, found_payload, occupancy, output ready);
endinterface

FILE: src/keyed_circular_queue.sv
// Keyed circular queue top level: ring of DEPTH record cells plus sequencer.
// Insert and search rotate the full ring once while cell 0 is compared with
// the key, then commit the result in the finish state. Remove and unused
// codes go straight to the finish state. One request is in work at a time; a
// new one is taken while the previous response still waits in its register.
// arst_n clears count and control; record cells hold no reset value.
module keyed_circular_queue #(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	kcq_req_if.sink    req,
	kcq_rsp_if.source  rsp
);
	import kcq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [IW-1:0]    step_q;
	logic [CW-1:0]    count_q;
	logic [ACT_W-1:0] act_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             hit_q;
	logic [PAY_W-1:0] hit_pay_q;

	logic             rsp_vld_q;
	logic [ST_W-1:0]  rsp_status_q;
	logic             rsp_found_q;
	logic [PAY_W-1:0] rsp_pay_q;
	logic [OCC_W-1:0] rsp_occ_q;

	logic [KEY_W-1:0] cell_key [DEPTH];
	logic [PAY_W-1:0] cell_pay [DEPTH];
	cell_ctl_t        cell_ctl;

	logic             accept;
	logic             fin_go;
	logic [ST_W-1:0]  res_status;
	logic             res_found;
	logic [PAY_W-1:0] res_pay;
	logic [CW-1:0]    res_count;
	logic             do_ins;
	logic             do_rem;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign fin_go = (state_q == S_FIN) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		res_status = ST_OK;
		res_found  = 1'b0;
		res_pay    = '0;
		res_count  = count_q;
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		unique case (act_q)
			ACT_INSERT: begin
				if (hit_q) begin
					res_status = ST_DUP;
					res_found  = 1'b1;
				end else if (count_q == FULL_CNT) begin
					res_status = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					res_count = count_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				if (count_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					do_rem    = 1'b1;
					res_count = count_q - CW'(1);
				end
			end
			ACT_SEARCH: begin
				if (hit_q) begin
					res_found = 1'b1;
					res_pay   = hit_pay_q;
				end else begin
					res_status = ST_NOTFOUND;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// Dropping the head is one rotation; the old head lands past the count.
	assign cell_ctl.shift = (state_q == S_WALK) || (fin_go && do_rem);
	assign cell_ctl.wr    = fin_go && do_ins;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kcq_cell #(
			.IW (IW),
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.wr_idx     (count_q[IW-1:0]),
			.wr_key     (key_q),
			.wr_payload (pay_q),
			.nxt_key    (cell_key[(i + 1) % DEPTH]),
			.nxt_payload(cell_pay[(i + 1) % DEPTH]),
			.key        (cell_key[i]),
			.payload    (cell_pay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			count_q   <= '0;
			hit_q     <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			// a new response may replace the one taken in this cycle
			if (fin_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q  <= 1'b0;
						step_q <= '0;
						if (req.action == ACT_INSERT || req.action == ACT_SEARCH) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_WALK: begin
					// cell 0 holds the record at logical position step_q
					if (!hit_q && CW'(step_q) < count_q && cell_key[0] == key_q) begin
						hit_q <= 1'b1;
					end
					step_q <= step_q + IW'(1);
					if (step_q == LAST_STEP) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						count_q <= res_count;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			key_q <= req.key;
			pay_q <= req.payload;
		end
		if (state_q == S_WALK && !hit_q) begin
			hit_pay_q <= cell_pay[0];
		end
		if (fin_go) begin
			rsp_status_q <= res_status;
			rsp_found_q  <= res_found;
			rsp_pay_q    <= res_pay;
			rsp_occ_q    <= OCC_W'(res_count);
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.found         = rsp_found_q;
	assign rsp.found_payload = rsp_pay_q;
	assign rsp.occupancy     = rsp_occ_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("record count above depth");

	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cell_ctl.shift && cell_ctl.wr))
		else $error("cell load and rotate at once");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer idle after accepting a word");

	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_go |=> $stable(count_q))
		else $error("count changed outside commit");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_found_q |-> rsp_status_q == ST_OK || rsp_status_q == ST_DUP)
		else $error("found flag with failing status");
`endif

endmodule

FILE: src/kcq_cell.sv
// One record cell of the rotating ring: key and payload, load or shift.
module kcq_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  kcq_pkg::cell_ctl_t       ctl,
	input  logic [IW-1:0]            wr_idx,
	input  logic [kcq_pkg::KEY_W-1:0] wr_key,
	input  logic [kcq_pkg::PAY_W-1:0] wr_payload,
	input  logic [kcq_pkg::KEY_W-1:0] nxt_key,
	input  logic [kcq_pkg::PAY_W-1:0] nxt_payload,
	output logic [kcq_pkg::KEY_W-1:0] key,
	output logic [kcq_pkg::PAY_W-1:0] payload
);
	import kcq_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && wr_idx == MY_IDX) begin
			key_q <= wr_key;
			pay_q <= wr_payload;
		end else if (ctl.shift) begin
			key_q <= nxt_key;
			pay_q <= nxt_payload;
		end
	end

	assign key     = key_q;
	assign payload = pay_q;

endmodule
